// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by msx_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/msx_pkg.sv
// ---------------------------------------------------------------------------
// msx_pkg
// types and constants of the marker string extractor
// ---------------------------------------------------------------------------
package msx_pkg;

	// capture buffer geometry
	localparam int LINE_CAP   = 64;
	localparam int LINE_DEPTH = LINE_CAP - 1;
	localparam int CNT_W      = $clog2(LINE_CAP);
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// characters of interest
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_mark;
	} msx_in_t;

	typedef struct packed {
		logic [6:0] text_byte;
		logic       last_of_string;
	} msx_out_t;

	typedef enum logic [3:0] {
		ST_SEARCH,
		ST_AT,
		ST_PAREN,
		ST_HASH,
		ST_SKIP,
		ST_CAPT,
		ST_DONE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} msx_state_t;

	// controller to datapath
	typedef struct packed {
		logic store;
		logic clr_cnt;
		logic ptr_clr;
		logic rd_en;
		logic load_out;
		logic ptr_inc;
	} msx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic end_mark;
		logic is_at;
		logic is_lparen;
		logic is_hash;
		logic is_rparen;
		logic is_blank;
		logic is_print;
		logic is_term;
		logic cnt_full;
		logic last_rd;
		logic out_free;
		logic first_only;
	} msx_sts_t;

endpackage

// File: rtl/core/msx_ram.sv
// ---------------------------------------------------------------------------
// msx_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module msx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/msx_ctrl.sv
// ---------------------------------------------------------------------------
// msx_ctrl
// marker scan and emission state machine
// ---------------------------------------------------------------------------
module msx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  msx_pkg::msx_sts_t sts,
	output msx_pkg::msx_cmd_t cmd
);
	import msx_pkg::*;

	msx_state_t state_q, state_d;
	logic       ret_done_q, ret_done_d;
	logic       accept;

	// input is taken in every scanning state
	assign in_ready = (state_q != ST_EMIT_RD) && (state_q != ST_EMIT_LD);
	assign accept   = in_valid && in_ready;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SEARCH;
			ret_done_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_done_q <= ret_done_d;
		end
	end

	// next state
	always_comb begin
		state_d    = state_q;
		ret_done_d = ret_done_q;
		if (accept && sts.end_mark) begin
			if (state_q == ST_CAPT) begin
				state_d    = ST_EMIT_RD;
				ret_done_d = 1'b0;
			end else begin
				state_d = ST_SEARCH;
			end
		end else if (accept) begin
			case (state_q)
				ST_SEARCH: begin
					if (sts.is_at) state_d = ST_AT;
				end
				ST_AT: begin
					if (sts.is_lparen) state_d = ST_PAREN;
					else if (!sts.is_at) state_d = ST_SEARCH;
				end
				ST_PAREN: begin
					if (sts.is_hash) state_d = ST_HASH;
					else if (sts.is_at) state_d = ST_AT;
					else state_d = ST_SEARCH;
				end
				ST_HASH: begin
					if (sts.is_rparen) state_d = ST_SKIP;
					else if (sts.is_at) state_d = ST_AT;
					else state_d = ST_SEARCH;
				end
				ST_SKIP: begin
					if (sts.is_blank) state_d = ST_SKIP;
					else if (sts.is_print) state_d = ST_CAPT;
					else state_d = ST_SEARCH;
				end
				ST_CAPT: begin
					if (sts.is_term) begin
						state_d    = ST_EMIT_RD;
						ret_done_d = sts.first_only;
					end else if (sts.cnt_full) begin
						state_d = ST_SEARCH;
					end
				end
				ST_DONE: state_d = ST_DONE;
				default: state_d = ST_SEARCH;
			endcase
		end else begin
			case (state_q)
				ST_EMIT_RD: state_d = ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (sts.out_free) begin
						if (sts.last_rd) state_d = ret_done_q ? ST_DONE : ST_SEARCH;
						else state_d = ST_EMIT_RD;
					end
				end
				default: state_d = state_q;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		if (accept && sts.end_mark) begin
			cmd.ptr_clr = (state_q == ST_CAPT);
			cmd.clr_cnt = (state_q != ST_CAPT);
		end else if (accept) begin
			case (state_q)
				ST_SKIP: begin
					cmd.store = !sts.is_blank && sts.is_print;
				end
				ST_CAPT: begin
					cmd.ptr_clr = sts.is_term;
					cmd.clr_cnt = !sts.is_term && sts.cnt_full;
					cmd.store   = !sts.is_term && !sts.cnt_full;
				end
				default: cmd = '0;
			endcase
		end else begin
			case (state_q)
				ST_EMIT_RD: cmd.rd_en = 1'b1;
				ST_EMIT_LD: begin
					cmd.load_out = sts.out_free;
					cmd.clr_cnt  = sts.out_free && sts.last_rd;
					cmd.ptr_inc  = sts.out_free && !sts.last_rd;
				end
				default: cmd = '0;
			endcase
		end
	end

endmodule

// File: rtl/core/msx_dp.sv
// ---------------------------------------------------------------------------
// msx_dp
// byte classification, capture buffer, counters and output register
// ---------------------------------------------------------------------------
module msx_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  msx_pkg::msx_in_t  in_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  msx_pkg::msx_cmd_t cmd,
	output msx_pkg::msx_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output msx_pkg::msx_out_t out_data
);
	import msx_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             first_only_q;
	logic             out_valid_q;
	msx_out_t         out_q;
	logic [6:0]       rd_data;
	logic [7:0]       c;

	assign c = in_data.data_byte;

	// byte classes and control status
	always_comb begin
		sts.end_mark   = in_data.end_mark;
		sts.is_at      = (c == CH_AT);
		sts.is_lparen  = (c == CH_LPAREN);
		sts.is_hash    = (c == CH_HASH);
		sts.is_rparen  = (c == CH_RPAREN);
		sts.is_blank   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		sts.is_print   = (c >= CH_SPACE) && (c <= CH_TILDE);
		sts.is_term    = (c == CH_NUL) || (c == CH_NL) || c[7];
		sts.cnt_full   = (count_q >= CNT_W'(LINE_DEPTH));
		sts.last_rd    = ((ptr_q + CNT_W'(1)) == count_q);
		sts.out_free   = !out_valid_q || out_ready;
		sts.first_only = first_only_q;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_only_q <= 1'b0;
		end else if (cfg_we) begin
			first_only_q <= cfg_wdata;
		end
	end

	// fill count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.clr_cnt) count_q <= '0;
			else if (cmd.store) count_q <= count_q + CNT_W'(1);
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_inc) ptr_q <= ptr_q + CNT_W'(1);
		end
	end

	// capture buffer
	msx_ram #(
		.WIDTH (7),
		.DEPTH (LINE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.store),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (c[6:0]),
		.rd_en   (cmd.rd_en),
		.rd_addr (ptr_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.text_byte      <= rd_data;
			out_q.last_of_string <= sts.last_rd;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/marker_string_extractor_core.sv
// ---------------------------------------------------------------------------
// marker_string_extractor_core
// identification string extractor: finds @(#) and emits the text after it
// ---------------------------------------------------------------------------
// While scanning the block takes one byte per cycle. When a terminator (NUL,
// newline, a byte above 127) or an end mark ends a capture, input stalls and
// the stored string is read back from the capture ram: each byte takes a
// registered ram read and then a load of the output register, and waits out
// any output stall. The output register lets the final byte of a string wait
// while scanning resumes. Up to LINE_CAP-1 bytes are held; one more non
// terminating byte drops the capture without output. The capture ram is not
// cleared after reset; only bytes written in the current capture are read.
module marker_string_extractor_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  msx_pkg::msx_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output msx_pkg::msx_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import msx_pkg::*;

	msx_cmd_t cmd;
	msx_sts_t sts;

	// control
	msx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	msx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/core/msx_checker.sv
// ---------------------------------------------------------------------------
// msx_checker
// port level checks of the marker string extractor
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msx_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input msx_pkg::msx_out_t out_data
);
	import msx_pkg::*;

	// stalled output transaction holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")

	// a pending byte that is not the last one means emission is running
	`ASSERT_CLK(a_mid_string_stall, (out_valid && !out_data.last_of_string) |-> !in_ready, "input taken mid string")

	// emission only starts after an input transaction
	`ASSERT_CLK(a_fell_after_accept, $fell(in_ready) |-> $past(in_valid && in_ready), "input stalled without a transaction")

	// scanning resumes exactly when the last byte is loaded
	`ASSERT_CLK(a_rose_with_last, $rose(in_ready) |-> (out_valid && out_data.last_of_string), "scan resumed without last byte")

endmodule

bind marker_string_extractor_core msx_checker u_msx_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives byte streams through the marker string extractor and checks every
// emitted byte against a behavioral scanner kept inside the bench
// ---------------------------------------------------------------------------
module testbench;
	import msx_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int FINAL_CYCLES  = 150;
	localparam int PHASE_ITEMS   = 85;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	msx_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	msx_out_t out_data;
	logic     cfg_we    = 1'b0;
	logic     cfg_wdata = 1'b0;

	// bytes waiting to be offered, and text bytes the block still owes us
	msx_in_t  stream_q[$];
	msx_out_t expected_text[$];

	// scanner state mirrored in the bench
	msx_state_t scan_state     = ST_SEARCH;
	logic [6:0] capt_buf [0:LINE_DEPTH-1];
	int         capt_cnt       = 0;
	logic       first_only_cfg = 1'b0;

	int items_sent   = 0;
	int strings_seen = 0;
	int bytes_seen   = 0;
	int drops        = 0;
	int errors       = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int idle_cycles  = 0;
	bit hold_req     = 1'b0;
	bit hold_done    = 1'b0;
	bit calm         = 1'b0;

	marker_string_extractor_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #10 clk = ~clk;

	// whitespace skipped after the marker
	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// queue the captured string, last byte flagged
	function automatic void flush_capture();
		for (int k = 0; k < capt_cnt; k++) begin
			expected_text.push_back('{text_byte: capt_buf[k], last_of_string: (k == capt_cnt - 1)});
		end
		capt_cnt = 0;
	endfunction

	// advance the scanner by one accepted transaction
	function automatic void extract_step(msx_in_t it);
		logic [7:0] c;
		c = it.data_byte;
		if (it.end_mark) begin
			if (scan_state == ST_CAPT)
				flush_capture();
			scan_state = ST_SEARCH;
			capt_cnt = 0;
			return;
		end
		case (scan_state)
			ST_SEARCH: begin
				if (c == CH_AT)
					scan_state = ST_AT;
			end
			ST_AT: begin
				if (c == CH_LPAREN)
					scan_state = ST_PAREN;
				else if (c != CH_AT)
					scan_state = ST_SEARCH;
			end
			ST_PAREN: begin
				if (c == CH_HASH)
					scan_state = ST_HASH;
				else if (c == CH_AT)
					scan_state = ST_AT;
				else
					scan_state = ST_SEARCH;
			end
			ST_HASH: begin
				if (c == CH_RPAREN)
					scan_state = ST_SKIP;
				else if (c == CH_AT)
					scan_state = ST_AT;
				else
					scan_state = ST_SEARCH;
			end
			ST_SKIP: begin
				if (!is_blank(c)) begin
					if (c >= CH_SPACE && c <= CH_TILDE) begin
						capt_buf[0] = c[6:0];
						capt_cnt = 1;
						scan_state = ST_CAPT;
					end else begin
						scan_state = ST_SEARCH;
					end
				end
			end
			ST_CAPT: begin
				if (c == CH_NUL || c == CH_NL || c[7]) begin
					flush_capture();
					scan_state = first_only_cfg ? ST_DONE : ST_SEARCH;
				end else if (capt_cnt >= LINE_DEPTH) begin
					// too long: the whole capture is lost
					capt_cnt = 0;
					drops++;
					scan_state = ST_SEARCH;
				end else begin
					capt_buf[capt_cnt] = c[6:0];
					capt_cnt++;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// stream building helpers
	function automatic void push_byte(logic [7:0] b);
		stream_q.push_back('{data_byte: b, end_mark: 1'b0});
	endfunction

	function automatic void push_end(logic [7:0] b);
		stream_q.push_back('{data_byte: b, end_mark: 1'b1});
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	// one random piece of stream: mostly marked strings, some noise
	function automatic void add_stream_segment();
		int         kind;
		int         len;
		logic [7:0] b;
		string      mk;
		mk = "@(#)";
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			// line noise
			repeat ($urandom_range(1, 6))
				push_byte(8'($urandom_range(0, 255)));
		end else if (kind < 20) begin
			// marker cut short or followed by a stray byte
			len = $urandom_range(1, 4);
			push_text(mk.substr(0, len - 1));
			push_byte($urandom_range(0, 1) ? CH_AT : 8'($urandom_range(0, 255)));
		end else if (kind < 27) begin
			push_end(8'($urandom_range(0, 255)));
		end else begin
			// well-formed marker and string
			repeat ($urandom_range(0, 2))
				push_byte(CH_AT);
			push_text(mk);
			repeat ($urandom_range(0, 2))
				push_byte($urandom_range(0, 3) == 0 ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
			push_byte(8'($urandom_range(8'h21, 8'h7E)));
			if ($urandom_range(0, 14) == 0)
				len = $urandom_range(LINE_CAP - 4, LINE_CAP + 2);
			else
				len = $urandom_range(1, 10);
			for (int i = 1; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					do
						b = 8'($urandom_range(1, 127));
					while (b == CH_NL);
				end else begin
					b = 8'($urandom_range(8'h20, 8'h7E));
				end
				push_byte(b);
			end
			case ($urandom_range(0, 3))
				0: push_byte(CH_NUL);
				1: push_byte(CH_NL);
				2: push_byte(8'($urandom_range(128, 255)));
				default: push_end(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// input driver with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				extract_step(in_data);
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (stream_q.size() > 0) begin
					in_data <= stream_q.pop_front();
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk) begin
		msx_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				bytes_seen++;
				if (out_data.last_of_string)
					strings_seen++;
				if (expected_text.size() == 0) begin
					$display("%0t unexpected transaction: text 0x%02h last %0b", $time,
						out_data.text_byte, out_data.last_of_string);
					errors++;
				end else begin
					want = expected_text.pop_front();
					if (out_data.text_byte !== want.text_byte ||
						out_data.last_of_string !== want.last_of_string) begin
						$display("%0t mismatch: expected text 0x%02h last %0b, actual text 0x%02h last %0b",
							$time, want.text_byte, want.last_of_string,
							out_data.text_byte, out_data.last_of_string);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				// long hold-off so the block backs up into its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// wait until everything is sent and received, then let the block settle
	task automatic settle(int extra);
		while (stream_q.size() != 0 || in_valid || expected_text.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_first_only(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_only_cfg = v;
	endtask

	task automatic run_random_phase();
		@(negedge clk);
		while (stream_q.size() < PHASE_ITEMS)
			add_stream_segment();
	endtask

	// sequence of phases
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_first_only(1'b0);

		// directed: at runs, restarts, blanks, terminators, abandon, end flush
		@(negedge clk);
		push_text("@@(#) \tA");
		push_byte(CH_NUL);
		push_text("@(@(#)B\n");
		push_text("@(#@(#)");
		push_byte(8'h01);
		push_text("@(#)~");
		push_end(8'hFF);
		push_text("@(#)x");
		push_byte(8'h80);
		settle(SETTLE_CYCLES);

		write_first_only(1'b1);
		run_random_phase();
		settle(SETTLE_CYCLES);

		write_first_only(1'b0);
		@(negedge clk);
		hold_req = 1'b1;
		run_random_phase();
		settle(SETTLE_CYCLES);

		write_first_only(1'b1);
		run_random_phase();
		settle(SETTLE_CYCLES);

		// closing phase runs without idling
		write_first_only(1'b0);
		@(negedge clk);
		calm = 1'b1;
		run_random_phase();
		settle(FINAL_CYCLES);

		$display("%0d stream bytes and end marks sent with first_only toggled 0/1/0/1/0", items_sent);
		$display("%0d strings (%0d bytes) compared, %0d over-long captures dropped",
			strings_seen, bytes_seen, drops);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
